/* hw/rtl/blbw_pkg.sv */
// Package: types, constants and parameters of the bilinear light basis weights unit.
package blbw_pkg;

  localparam int unsigned MAX_PLANES_DEF     = 18;
  localparam int unsigned MAX_RESOLUTION_DEF = 8;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_RES    = 1'b1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_LIGHT = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic        [11:0] basis_index;
    logic signed [31:0] basis_value;
    logic signed [15:0] light_x;
    logic signed [15:0] light_y;
  } in_item_t;

  typedef struct packed {
    logic        [5:0]  weight_index;
    logic signed [31:0] weight_value;
    logic               last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RAD,
    ST_SQRT,
    ST_SUM,
    ST_MULX,
    ST_DIVX,
    ST_MULY,
    ST_DIVY,
    ST_CELL,
    ST_WGT,
    ST_RD,
    ST_ACC,
    ST_EMIT
  } state_t;

endpackage

/* hw/rtl/blbw_ram.sv */
// Generic single-port synchronous RAM with registered read.
module blbw_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 3648,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* hw/rtl/bilinear_light_basis_weights_unit.sv */
// Top level: light direction to bilinear basis weights over a basis store.
//
// Requests come in on in_start/in_item while in_busy is low. A load request
// (opcode 0) writes one word of the basis store and gives no result; loads can
// follow each other every cycle. A light request (opcode 1) gives
// (plane_count+1)*3 weights, one per strobe on out_valid, in index order, with
// last set on the final one. Configuration (plane count, grid resolution) is
// written through cfg_we, cfg_index and cfg_data while the block is idle;
// out-of-range values are saturated when used.
// Steps of a light request: set-up (radicand, 16-step square root, sum, scaling
// and two 40-step long divisions, cell and corner weights), then per weight:
// four corner reads from the single store port, a wait while the read,
// multiply and accumulate pipe drains, and an emit. in_busy stays high until
// the final weight is emitted.
// Reset (synchronous, rst_n low) returns control to idle and the registers to
// plane_count 9, grid_resolution 8; the store is not cleared. The receiver
// cannot stall: each weight is shown for exactly one cycle.
module bilinear_light_basis_weights_unit #(
  parameter int unsigned MAX_PLANES     = blbw_pkg::MAX_PLANES_DEF,
  parameter int unsigned MAX_RESOLUTION = blbw_pkg::MAX_RESOLUTION_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_start,
  output logic                                in_busy,
  input  blbw_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  output blbw_pkg::out_item_t                 out_item,
  input  logic                                cfg_we,
  input  logic [blbw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [blbw_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned DEPTH = (MAX_PLANES + 1) * MAX_RESOLUTION * MAX_RESOLUTION * 3;
  localparam int unsigned AW    = $clog2(DEPTH);

  blbw_pkg::state_t state_r, state_nxt;

  logic [4:0]  np_cfg_r;
  logic [3:0]  res_cfg_r;
  logic [4:0]  np_r;
  logic [3:0]  res_r;

  logic signed [15:0] lx_r, ly_r;
  logic [31:0] rad_r;
  logic [15:0] root_r;
  logic [31:0] rem_r;
  logic [4:0]  cnt_r;
  logic [17:0] s_r;
  logic [39:0] num_r;
  logic [40:0] drem_r;
  logic [39:0] quo_r;
  logic [39:0] ux_r, uy_r;
  logic [5:0]  cnt6_r;
  logic [3:0]  cx_r, cy_r;
  logic [16:0] dx_r, dy_r;
  logic [32:0] w_r [4];
  logic [4:0]  p_r;
  logic [1:0]  k_r;
  logic [1:0]  corner_r;
  logic [2:0]  phase_r;
  logic signed [66:0] acc_r;
  logic signed [66:0] prod_r;
  logic [5:0]  idx_r;

  logic [AW-1:0] ram_addr;
  logic          ram_we;
  logic [31:0]   ram_rdata;

  logic signed [16:0] lx_abs, ly_abs;
  logic signed [17:0] nx_s, ny_s;
  logic [32:0] trial;
  logic [41:0] dsub;
  logic [3:0]  rm2;
  logic [AW-1:0] rd_addr;
  logic [15:0] cell_idx;

  always_comb begin
    lx_abs = lx_r[15] ? -17'(lx_r) : 17'(lx_r);
    ly_abs = ly_r[15] ? -17'(ly_r) : 17'(ly_r);
    nx_s   = 18'(lx_r) + 18'(ly_r) + 18'(s_r);
    ny_s   = 18'(ly_r) - 18'(lx_r) + 18'(s_r);
    trial  = 33'({rem_r[29:0], rad_r[31:30]}) - 33'({root_r, 2'b01});
    dsub   = {drem_r, num_r[39]} - 42'({s_r, 1'b0});
    rm2    = res_r - 4'd2;
    unique case (corner_r)
      2'd0:    cell_idx = 16'(cy_r) * 16'(res_r) + 16'(cx_r);
      2'd1:    cell_idx = 16'(cy_r) * 16'(res_r) + 16'(cx_r) + 16'd1;
      2'd2:    cell_idx = 16'(cy_r + 4'd1) * 16'(res_r) + 16'(cx_r);
      default: cell_idx = 16'(cy_r + 4'd1) * 16'(res_r) + 16'(cx_r) + 16'd1;
    endcase
    rd_addr = AW'((32'(p_r) * 32'(res_r) * 32'(res_r) + 32'(cell_idx)) * 32'd3 + 32'(k_r));
  end

  assign ram_we   = (state_r == blbw_pkg::ST_IDLE) && in_start &&
                    (in_item.opcode == blbw_pkg::OP_LOAD) &&
                    (32'(in_item.basis_index) < 32'(DEPTH));
  assign ram_addr = ram_we ? AW'(in_item.basis_index) : rd_addr;

  blbw_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_item.basis_value),
    .rdata (ram_rdata)
  );

  assign in_busy = (state_r != blbw_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      blbw_pkg::ST_IDLE:
        if (in_start && in_item.opcode == blbw_pkg::OP_LIGHT) state_nxt = blbw_pkg::ST_RAD;
      blbw_pkg::ST_RAD:  state_nxt = blbw_pkg::ST_SQRT;
      blbw_pkg::ST_SQRT: if (cnt_r == 5'd15) state_nxt = blbw_pkg::ST_SUM;
      blbw_pkg::ST_SUM:  state_nxt = blbw_pkg::ST_MULX;
      blbw_pkg::ST_MULX: state_nxt = blbw_pkg::ST_DIVX;
      blbw_pkg::ST_DIVX: if (cnt6_r == 6'd39) state_nxt = blbw_pkg::ST_MULY;
      blbw_pkg::ST_MULY: state_nxt = blbw_pkg::ST_DIVY;
      blbw_pkg::ST_DIVY: if (cnt6_r == 6'd39) state_nxt = blbw_pkg::ST_CELL;
      blbw_pkg::ST_CELL: state_nxt = blbw_pkg::ST_WGT;
      blbw_pkg::ST_WGT:  state_nxt = blbw_pkg::ST_RD;
      blbw_pkg::ST_RD:   if (corner_r == 2'd3) state_nxt = blbw_pkg::ST_ACC;
      blbw_pkg::ST_ACC:  if (phase_r == 3'd2) state_nxt = blbw_pkg::ST_EMIT;
      blbw_pkg::ST_EMIT:
        if (p_r == np_r && k_r == 2'd2) state_nxt = blbw_pkg::ST_IDLE;
        else state_nxt = blbw_pkg::ST_RD;
      default: state_nxt = blbw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= blbw_pkg::ST_IDLE;
      np_cfg_r  <= 5'd9;
      res_cfg_r <= 4'd8;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= (state_r == blbw_pkg::ST_EMIT);
      if (cfg_we) begin
        unique case (cfg_index)
          blbw_pkg::CFG_PLANE_COUNT: np_cfg_r  <= cfg_data;
          blbw_pkg::CFG_GRID_RES:    res_cfg_r <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  // Read pipeline: corners addressed in ST_RD, data in the next cycle, product in the cycle after that.
  logic [1:0] rd_corner_r;
  logic       rd_v_r, pr_v_r;

  always_ff @(posedge clk) begin
    unique case (state_r)
      blbw_pkg::ST_IDLE: begin
        lx_r <= in_item.light_x;
        ly_r <= in_item.light_y;
        if (np_cfg_r < 5'd1) np_r <= 5'd1;
        else if (32'(np_cfg_r) > 32'(MAX_PLANES)) np_r <= 5'(MAX_PLANES);
        else np_r <= np_cfg_r;
        if (res_cfg_r < 4'd2) res_r <= 4'd2;
        else if (32'(res_cfg_r) > 32'(MAX_RESOLUTION)) res_r <= 4'(MAX_RESOLUTION);
        else res_r <= res_cfg_r;
      end
      blbw_pkg::ST_RAD: begin
        logic signed [33:0] r;
        r = 34'sd1073741824 - 34'(lx_r * lx_r) - 34'(ly_r * ly_r);
        rad_r  <= r[33] ? 32'd0 : r[31:0];
        rem_r  <= 32'd0;
        root_r <= 16'd0;
        cnt_r  <= 5'd0;
      end
      blbw_pkg::ST_SQRT: begin
        if (!trial[32]) begin
          rem_r  <= trial[31:0];
          root_r <= {root_r[14:0], 1'b1};
        end else begin
          rem_r  <= {rem_r[29:0], rad_r[31:30]};
          root_r <= {root_r[14:0], 1'b0};
        end
        rad_r <= {rad_r[29:0], 2'b00};
        cnt_r <= cnt_r + 5'd1;
      end
      blbw_pkg::ST_SUM:
        s_r <= 18'(lx_abs) + 18'(ly_abs) + 18'(root_r);
      blbw_pkg::ST_MULX, blbw_pkg::ST_MULY: begin
        logic [23:0] scaled;
        scaled = (state_r == blbw_pkg::ST_MULX) ? 24'($unsigned(nx_s)) : 24'($unsigned(ny_s));
        scaled = scaled * 24'(res_r - 4'd1);
        num_r  <= {scaled, 16'd0};
        drem_r <= 41'd0;
        cnt6_r <= 6'd0;
      end
      blbw_pkg::ST_DIVX, blbw_pkg::ST_DIVY: begin
        logic [39:0] q;
        if (!dsub[41]) begin
          drem_r <= dsub[40:0];
          q = {quo_r[38:0], 1'b1};
        end else begin
          drem_r <= {drem_r[39:0], num_r[39]};
          q = {quo_r[38:0], 1'b0};
        end
        quo_r  <= q;
        num_r  <= {num_r[38:0], 1'b0};
        cnt6_r <= cnt6_r + 6'd1;
        if (cnt6_r == 6'd39) begin
          if (state_r == blbw_pkg::ST_DIVX) ux_r <= q;
          else uy_r <= q;
        end
      end
      blbw_pkg::ST_CELL: begin
        logic [3:0] cx, cy;
        cx = (ux_r[39:16] > 24'(rm2)) ? rm2 : ux_r[19:16];
        cy = (uy_r[39:16] > 24'(rm2)) ? rm2 : uy_r[19:16];
        cx_r <= cx;
        cy_r <= cy;
        dx_r <= 17'(ux_r - {20'd0, cx, 16'd0});
        dy_r <= 17'(uy_r - {20'd0, cy, 16'd0});
      end
      blbw_pkg::ST_WGT: begin
        w_r[0] <= 33'((17'h10000 - dx_r) * (17'h10000 - dy_r));
        w_r[1] <= 33'(dx_r * (17'h10000 - dy_r));
        w_r[2] <= 33'((17'h10000 - dx_r) * dy_r);
        w_r[3] <= 33'(dx_r * dy_r);
        p_r      <= 5'd0;
        k_r      <= 2'd0;
        idx_r    <= 6'd0;
        corner_r <= 2'd0;
        acc_r    <= 67'sd2147483648;
      end
      blbw_pkg::ST_RD:
        corner_r <= corner_r + 2'd1;
      blbw_pkg::ST_ACC: ;
      blbw_pkg::ST_EMIT: begin
        out_item.weight_index <= idx_r;
        out_item.weight_value <= acc_r[63:32];
        out_item.last         <= (p_r == np_r && k_r == 2'd2);
        acc_r    <= 67'sd2147483648;
        corner_r <= 2'd0;
        idx_r    <= idx_r + 6'd1;
        if (k_r == 2'd2) begin
          k_r <= 2'd0;
          p_r <= p_r + 5'd1;
        end else begin
          k_r <= k_r + 2'd1;
        end
      end
      default: ;
    endcase

    rd_v_r      <= (state_r == blbw_pkg::ST_RD);
    rd_corner_r <= corner_r;
    pr_v_r      <= rd_v_r;
    prod_r      <= $signed({1'b0, w_r[rd_corner_r]}) * $signed(ram_rdata);
    if (pr_v_r) acc_r <= acc_r + prod_r;
    if (state_r == blbw_pkg::ST_ACC) phase_r <= phase_r + 3'd1;
    else phase_r <= 3'd0;
  end

endmodule
